>>> src/dda_pkg.sv
// Shared types, constants and calendar tables for the date offset calculator.
package dda_pkg;

    localparam int DAY_W = 22;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SUB   = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_YEAR  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    localparam logic [13:0]      YEAR_MAX   = 14'd9999;
    localparam logic [10:0]      CYCLE_DAYS = 11'd1461;
    localparam logic [DAY_W-1:0] MAX_NUM    = 22'd3652499;
    localparam logic [DAY_W-1:0] COUNT_MAX  = 22'h3FFFFF;
    localparam logic [3:0]       LAST_MONTH = 4'd12;

    // 2^33 / 1461 rounded up: exact quotient for any 22-bit day number.
    localparam logic [22:0]      CYCLE_RECIP = 23'd5879490;
    localparam int               RECIP_SHIFT = 33;

    typedef logic [3:0] step_t;

    localparam step_t STEP_CHECK = 4'd0;
    localparam step_t STEP_MUL_S = 4'd1;
    localparam step_t STEP_ADD_S = 4'd2;
    localparam step_t STEP_MUL_E = 4'd3;
    localparam step_t STEP_ADD_E = 4'd4;
    localparam step_t STEP_ARITH = 4'd5;
    localparam step_t STEP_QUO   = 4'd6;
    localparam step_t STEP_REM   = 4'd7;
    localparam step_t STEP_YEAR  = 4'd8;
    localparam step_t STEP_MONTH = 4'd9;
    localparam step_t STEP_DONE  = 4'd10;

    typedef enum logic [3:0] {
        OP_CHECK,
        OP_MUL,
        OP_ADD,
        OP_ARITH,
        OP_QUO,
        OP_REM,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } dp_op_t;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_ERR,
        JMP_RANGE_ERR,
        JMP_MONTH_MORE,
        JMP_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_end;
        cond_t  cond;
        step_t  target;
    } ctl_word_t;

    typedef struct packed {
        logic err;
        logic is_range;
        logic month_more;
    } dp_flags_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m) inside
            4'd2:                   n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Offset of year k within a four-year cycle that starts on a leap year.
    function automatic logic [10:0] year_base(input logic [1:0] k);
        logic [10:0] n;
        case (k)
            2'd1:    n = 11'd366;
            2'd2:    n = 11'd731;
            2'd3:    n = 11'd1096;
            default: n = 11'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] check_date(input logic [3:0] m, input logic [4:0] d,
                                              input logic [13:0] y);
        logic [1:0] r;
        if (y > YEAR_MAX) begin
            r = ST_YEAR;
        end else if (m < 4'd1 || m > LAST_MONTH) begin
            r = ST_BAD;
        end else if (d < 5'd1 || d > month_len(m, y[1:0] == 2'd0)) begin
            r = ST_BAD;
        end else begin
            r = ST_OK;
        end
        return r;
    endfunction

endpackage

>>> src/dda_if.sv
// Request and response channel interfaces for the date offset calculator.
interface dda_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [13:0] start_year;
    logic [21:0] day_offset;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [13:0] end_year;

    modport source (
        output valid, command, start_month, start_day, start_year, day_offset,
               end_month, end_day, end_year,
        input  ready
    );
    modport sink (
        input  valid, command, start_month, start_day, start_year, day_offset,
               end_month, end_day, end_year,
        output ready
    );
endinterface

interface dda_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [13:0] result_year;
    logic [21:0] day_count;
    logic [1:0]  status;

    modport source (
        output valid, result_month, result_day, result_year, day_count, status,
        input  ready
    );
    modport sink (
        input  valid, result_month, result_day, result_year, day_count, status,
        output ready
    );
endinterface

>>> src/dda_rom.sv
// Control store: one control word per program step.
module dda_rom
    import dda_pkg::*;
(
    input  step_t     pc,
    output ctl_word_t word
);

    always_comb
    begin
        unique case (pc)
            STEP_CHECK: word = '{OP_CHECK, 1'b0, JMP_ERR,        STEP_DONE};
            STEP_MUL_S: word = '{OP_MUL,   1'b0, JMP_NONE,       STEP_CHECK};
            STEP_ADD_S: word = '{OP_ADD,   1'b0, JMP_NONE,       STEP_CHECK};
            STEP_MUL_E: word = '{OP_MUL,   1'b1, JMP_NONE,       STEP_CHECK};
            STEP_ADD_E: word = '{OP_ADD,   1'b1, JMP_NONE,       STEP_CHECK};
            STEP_ARITH: word = '{OP_ARITH, 1'b0, JMP_RANGE_ERR,  STEP_DONE};
            STEP_QUO:   word = '{OP_QUO,   1'b0, JMP_NONE,       STEP_CHECK};
            STEP_REM:   word = '{OP_REM,   1'b0, JMP_NONE,       STEP_CHECK};
            STEP_YEAR:  word = '{OP_YEAR,  1'b0, JMP_NONE,       STEP_CHECK};
            STEP_MONTH: word = '{OP_MONTH, 1'b0, JMP_MONTH_MORE, STEP_MONTH};
            STEP_DONE:  word = '{OP_DONE,  1'b0, JMP_OUT_BUSY,   STEP_DONE};
            default:    word = '{OP_DONE,  1'b0, JMP_NONE,       STEP_DONE};
        endcase
    end

endmodule

>>> src/dda_datapath.sv
// Datapath: request registers, day-number arithmetic, cycle split and month walk.
module dda_datapath
    import dda_pkg::*;
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic        clk,
    input  logic        load,
    input  logic        run,
    input  ctl_word_t   word,
    input  logic [1:0]  command,
    input  logic [3:0]  start_month,
    input  logic [4:0]  start_day,
    input  logic [13:0] start_year,
    input  logic [21:0] day_offset,
    input  logic [3:0]  end_month,
    input  logic [4:0]  end_day,
    input  logic [13:0] end_year,
    output dp_flags_t   flags,
    output logic [3:0]  res_month,
    output logic [4:0]  res_day,
    output logic [13:0] res_year,
    output logic [21:0] res_count,
    output logic [1:0]  res_status
);

    localparam logic [63:0] LIM_WIDE = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [DAY_W-1:0] CNT_LIM =
        (LIM_WIDE > 64'(COUNT_MAX)) ? COUNT_MAX : LIM_WIDE[DAY_W-1:0];

    logic [1:0]       cmd_reg;
    logic [3:0]       sm_reg, em_reg;
    logic [4:0]       sd_reg, ed_reg;
    logic [13:0]      sy_reg, ey_reg;
    logic [DAY_W-1:0] off_reg;

    logic [1:0]       st_reg, st_next;
    logic [DAY_W-1:0] prod_reg, prod_next;
    logic [DAY_W-1:0] s_reg, s_next;
    logic [DAY_W-1:0] e_reg, e_next;
    logic [DAY_W-1:0] cnt_reg, cnt_next;
    logic [DAY_W-1:0] rem_reg, rem_next;
    logic [11:0]      quo_reg, quo_next;
    logic [13:0]      yr_reg, yr_next;
    logic [3:0]       mon_reg, mon_next;

    logic [3:0]       sel_m;
    logic [4:0]       sel_d;
    logic [13:0]      sel_y;
    logic [1:0]       cs, ce;
    logic [DAY_W:0]   sum;
    logic [44:0]      quo_prod;
    logic [DAY_W-1:0] num;
    logic [DAY_W-1:0] diff;
    logic [1:0]       k;
    logic [4:0]       mlen;
    logic             more;

    assign sel_m = word.sel_end ? em_reg : sm_reg;
    assign sel_d = word.sel_end ? ed_reg : sd_reg;
    assign sel_y = word.sel_end ? ey_reg : sy_reg;

    assign cs = check_date(sm_reg, sd_reg, sy_reg);
    assign ce = check_date(em_reg, ed_reg, ey_reg);

    assign sum      = {1'b0, s_reg} + {1'b0, off_reg};
    assign diff     = e_reg - s_reg;
    assign quo_prod = 45'(rem_reg) * 45'(CYCLE_RECIP);
    assign num      = prod_reg + DAY_W'(year_base(sel_y[1:0])) + DAY_W'(month_start(sel_m))
                    + DAY_W'(sel_m > 4'd2 && sel_y[1:0] == 2'd0) + DAY_W'(sel_d) - DAY_W'(1);

    assign k = (rem_reg >= DAY_W'(year_base(2'd3))) ? 2'd3 :
               (rem_reg >= DAY_W'(year_base(2'd2))) ? 2'd2 :
               (rem_reg >= DAY_W'(year_base(2'd1))) ? 2'd1 : 2'd0;

    assign mlen = month_len(mon_reg, yr_reg[1:0] == 2'd0);
    assign more = (rem_reg >= DAY_W'(mlen)) && (mon_reg != LAST_MONTH);

    always_comb
    begin
        st_next   = st_reg;
        prod_next = prod_reg;
        s_next    = s_reg;
        e_next    = e_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        yr_next   = yr_reg;
        mon_next  = mon_reg;
        unique case (word.op)
            OP_CHECK:
            begin
                unique case (cmd_reg)
                    CMD_ADD, CMD_SUB: st_next = cs;
                    CMD_RANGE:
                    begin
                        if (cs == ST_YEAR || ce == ST_YEAR) begin
                            st_next = ST_YEAR;
                        end else if (cs != ST_OK || ce != ST_OK) begin
                            st_next = ST_BAD;
                        end else begin
                            st_next = ST_OK;
                        end
                    end
                    default: st_next = ST_BAD;
                endcase
            end
            OP_MUL:
            begin
                prod_next = DAY_W'(sel_y[13:2]) * DAY_W'(CYCLE_DAYS);
            end
            OP_ADD:
            begin
                if (word.sel_end) begin
                    e_next = num;
                end else begin
                    s_next = num;
                end
            end
            OP_ARITH:
            begin
                if (cmd_reg == CMD_ADD) begin
                    if (sum > (DAY_W + 1)'(MAX_NUM)) begin
                        st_next = ST_YEAR;
                    end else begin
                        rem_next = sum[DAY_W-1:0];
                    end
                end else if (cmd_reg == CMD_SUB) begin
                    if (off_reg > s_reg) begin
                        st_next = ST_YEAR;
                    end else begin
                        rem_next = s_reg - off_reg;
                    end
                end else begin
                    if (e_reg < s_reg) begin
                        st_next = ST_ORDER;
                    end else begin
                        cnt_next = (diff > CNT_LIM) ? CNT_LIM : diff;
                    end
                end
            end
            OP_QUO:
            begin
                // four-year cycles by reciprocal multiplication
                quo_next = quo_prod[RECIP_SHIFT +: 12];
            end
            OP_REM:
            begin
                rem_next = rem_reg - DAY_W'(quo_reg) * DAY_W'(CYCLE_DAYS);
            end
            OP_YEAR:
            begin
                yr_next  = {quo_reg, 2'b00} + 14'(k);
                rem_next = rem_reg - DAY_W'(year_base(k));
                mon_next = 4'd1;
            end
            OP_MONTH:
            begin
                if (more) begin
                    rem_next = rem_reg - DAY_W'(mlen);
                    mon_next = mon_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            cmd_reg <= command;
            sm_reg  <= start_month;
            sd_reg  <= start_day;
            sy_reg  <= start_year;
            off_reg <= day_offset;
            em_reg  <= end_month;
            ed_reg  <= end_day;
            ey_reg  <= end_year;
        end else if (run) begin
            st_reg   <= st_next;
            prod_reg <= prod_next;
            s_reg    <= s_next;
            e_reg    <= e_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            yr_reg   <= yr_next;
            mon_reg  <= mon_next;
        end
    end

    assign flags.err        = (st_next != ST_OK);
    assign flags.is_range   = (cmd_reg == CMD_RANGE);
    assign flags.month_more = more;

    // zero every field that has no meaning for this command or status
    always_comb
    begin
        res_status = st_reg;
        res_month  = '0;
        res_day    = '0;
        res_year   = '0;
        res_count  = '0;
        if (st_reg == ST_OK) begin
            if (cmd_reg == CMD_RANGE) begin
                res_count = cnt_reg;
            end else begin
                res_month = mon_reg;
                res_day   = rem_reg[4:0] + 5'd1;
                res_year  = yr_reg;
            end
        end
    end

endmodule

>>> src/date_day_offset_calculator.sv
// Top level: step sequencer, request/response handshake and result register.
//
//  channel  modport          payload
//  req      dda_req_if.sink  command, start/end date, day_offset
//  rsp      dda_rsp_if.source result date, day_count, status
//
// One request at a time. A valid add or subtract splits off the four-year
// cycles by a reciprocal multiply, in a quotient and a remainder step, and
// then walks the months. A range request, or an add or subtract that leaves
// the calendar, ends at the arithmetic step, a rejected date at the check.
// rst_n clears the sequencer and the response valid; no clearing pass.
// A stalled response holds the sequencer in its last step; once the result
// register is loaded, the next request is taken in the following cycle.
module date_day_offset_calculator
    import dda_pkg::*;
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic             clk,
    input  logic             rst_n,
    dda_req_if.sink          req,
    dda_rsp_if.source        rsp
);

    logic        busy_reg, busy_next;
    step_t       pc_reg, pc_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [13:0] year_reg;
    logic [21:0] count_reg;
    logic [1:0]  status_reg;

    ctl_word_t   word;
    dp_flags_t   flags;
    logic        load;
    logic        take;
    logic        finish;
    logic [3:0]  res_month;
    logic [4:0]  res_day;
    logic [13:0] res_year;
    logic [21:0] res_count;
    logic [1:0]  res_status;

    assign req.ready = !busy_reg;
    assign load      = req.valid && !busy_reg;

    dda_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    dda_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .load        (load),
        .run         (busy_reg),
        .word        (word),
        .command     (req.command),
        .start_month (req.start_month),
        .start_day   (req.start_day),
        .start_year  (req.start_year),
        .day_offset  (req.day_offset),
        .end_month   (req.end_month),
        .end_day     (req.end_day),
        .end_year    (req.end_year),
        .flags       (flags),
        .res_month   (res_month),
        .res_day     (res_day),
        .res_year    (res_year),
        .res_count   (res_count),
        .res_status  (res_status)
    );

    always_comb
    begin
        unique case (word.cond)
            JMP_NONE:       take = 1'b0;
            JMP_ERR:        take = flags.err;
            JMP_RANGE_ERR:  take = flags.err || flags.is_range;
            JMP_MONTH_MORE: take = flags.month_more;
            JMP_OUT_BUSY:   take = out_valid_reg && !rsp.ready;
            default:        take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        finish    = 1'b0;
        if (load) begin
            pc_next   = STEP_CHECK;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (take) begin
                pc_next = word.target;
            end else if (word.op == OP_DONE) begin
                finish    = 1'b1;
                busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + step_t'(1);
            end
        end
    end

    always_comb
    begin
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (rsp.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            pc_reg        <= STEP_CHECK;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish) begin
            month_reg  <= res_month;
            day_reg    <= res_day;
            year_reg   <= res_year;
            count_reg  <= res_count;
            status_reg <= res_status;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_month = month_reg;
    assign rsp.result_day   = day_reg;
    assign rsp.result_year  = year_reg;
    assign rsp.day_count    = count_reg;
    assign rsp.status       = status_reg;

`ifndef SYNTHESIS
    a_start_at_check: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (busy_reg && pc_reg == STEP_CHECK))
        else $error("request accepted but program did not start at the check step");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_DONE))
        else $error("step counter left the program");

    a_finish_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> rsp.valid)
        else $error("sequencer went idle without a response");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
            (rsp.result_month == 4'd0 && rsp.result_day == 5'd0 &&
             rsp.result_year == 14'd0 && rsp.day_count == 22'd0))
        else $error("error response carries nonzero fields");

    a_date_has_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_OK && rsp.result_month != 4'd0) |->
            (rsp.result_day != 5'd0 && rsp.day_count == 22'd0))
        else $error("date response with a count or no day");
`endif

endmodule
